@@ rtl/mrtu_pkg.sv @@
// Shared types, codes and constants of the Modbus RTU master core.
package mrtu_pkg;

  localparam int unsigned MaxWordsDefault = 64;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0] ExcMask = 8'h80;

  // Input item kinds
  localparam logic [2:0] ReqStart = 3'd0;
  localparam logic [2:0] ReqByte = 3'd1;
  localparam logic [2:0] ReqTick = 3'd2;
  localparam logic [2:0] ReqRead = 3'd3;
  localparam logic [2:0] ReqClear = 3'd4;

  // Result kinds
  localparam logic [1:0] KindTx = 2'd0;
  localparam logic [1:0] KindWord = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;
  localparam logic [1:0] KindCount = 2'd3;

  // Status codes
  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadQty = 3'd1;
  localparam logic [2:0] StTimeout = 3'd2;
  localparam logic [2:0] StFrame = 3'd3;
  localparam logic [2:0] StExcept = 3'd4;
  localparam logic [2:0] StCrc = 3'd5;

  // Event counter indexes
  localparam logic [2:0] CntTrans = 3'd0;
  localparam logic [2:0] CntRetry = 3'd1;
  localparam logic [2:0] CntTimeout = 3'd2;
  localparam logic [2:0] CntFrame = 3'd3;
  localparam logic [2:0] CntExcept = 3'd4;
  localparam logic [2:0] CntCrc = 3'd5;
  localparam logic [2:0] CntOk = 3'd6;
  localparam logic [2:0] CntTicks = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CfgRetries = 2'd0;
  localparam logic [1:0] CfgTimeout = 2'd1;
  localparam logic [1:0] CfgTurn = 2'd2;

  // Protocol phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_EXHEAD = 3'd2,
    PH_EXTAIL = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Control between sequencer and CRC unit
  typedef struct packed {
    logic       load;
    logic [15:0] seed;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

@@ rtl/mrtu_ram.sv @@
// Generic RAM with one write port and one registered read port.
module mrtu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mrtu_crc.sv @@
// Bit-serial CRC-16/MODBUS unit: one shift per cycle, eight per byte.
module mrtu_crc
  import mrtu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  crc_cmd_t cmd,
  output logic     busy,
  output logic [15:0] crc
);

  logic [2:0] bit_cnt;

  // Load seed xor data, then shift eight times
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (cmd.load) begin
      busy <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc <= cmd.seed ^ {8'h00, cmd.data};
    end else if (busy) begin
      crc <= crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
  end

endmodule

@@ rtl/modbus_rtu_master_transaction_core.sv @@
// Top level of the Modbus RTU master read-register transaction core.
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tuser=req_type, tdata=request fields
//  m_axis  | out | m_axis_tvalid/tready   | tuser=out_kind, tdata=result, tlast
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// Control and tick items are handled in the dispatch state; a CRC-covered byte also
// passes the bit-serial CRC unit, which shifts one bit a cycle. A start runs the CRC
// over six header bytes, then makes eight transmit transfers; success emits the
// words one at a time, each read through the word RAM read port before it is sent.
// Output stalls hold the sequencer. Reset is synchronous; counters clear at reset.
module modbus_rtu_master_transaction_core
  import mrtu_pkg::*;
#(
  parameter int unsigned MaxWords = MaxWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slave_addr[7:0], function_code[15:8], start_addr[31:16], quantity[47:32],
  // rx_byte[55:48], counter_index[58:56], zero fill [63:59]
  input  logic [63:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0], data_word[23:8], status[26:24], counter_value[58:27], zero [63:59]
  output logic [63:0] m_axis_tdata,
  // out_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AddrW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned QtyW = $clog2(MaxWords + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_TXCRC  = 9'b000000100,
    S_TXSEND = 9'b000001000,
    S_RXCRC  = 9'b000010000,
    S_RXEND  = 9'b000100000,
    S_WREAD  = 9'b001000000,
    S_WSEND  = 9'b010000000,
    S_OUT    = 9'b100000000
  } seq_t;

  seq_t seq;
  phase_t phase;
  logic [3:0]  max_retries;
  logic [15:0] timeout_ticks;
  logic [15:0] turnaround_ticks;
  logic [3:0]  attempt_count;
  logic [7:0]  byte_position;
  logic [16:0] segment_ticks;
  logic [31:0] response_ticks;
  logic [15:0] running_crc;
  logic [7:0]  req_slave;
  logic [7:0]  req_func;
  logic [15:0] req_start;
  logic [QtyW-1:0] req_qty;
  logic [31:0] counters [8];
  logic [2:0]  in_type;
  logic [63:0] in_data;
  logic [2:0]  tx_idx;
  logic [15:0] tx_crc;
  logic [QtyW-1:0] word_idx;
  crc_cmd_t crc_cmd;
  logic        crc_busy;
  logic [15:0] crc_val;
  logic        ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0] ram_wdata;
  logic [15:0] ram_rdata;
  logic [15:0] hold_word;
  logic [7:0]  rx_b;
  logic [15:0] in_qty;
  logic [7:0]  tx_b;
  logic [16:0] limit;
  logic [16:0] seg_inc;
  logic [8:0]  expected;

  mrtu_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .busy (crc_busy),
    .crc  (crc_val)
  );

  mrtu_ram #(.Width(16), .Depth(MaxWords)) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (word_idx[AddrW-1:0]),
    .rdata (ram_rdata)
  );

  // Header byte following index i
  function automatic logic [7:0] tx_b_next(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = req_func;
      3'd1: b = req_start[15:8];
      3'd2: b = req_start[7:0];
      3'd3: b = 8'(req_qty >> 8);
      default: b = 8'(req_qty);
    endcase
    return b;
  endfunction

  assign s_axis_tready = (seq == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready = 1'b1;
  assign rx_b = in_data[55:48];
  assign in_qty = in_data[47:32];
  assign expected = {req_qty, 1'b0};
  assign seg_inc = (segment_ticks == 17'h1FFFF) ? segment_ticks : segment_ticks + 17'd1;
  assign limit = (phase == PH_HEAD || phase == PH_EXHEAD)
               ? {1'b0, turnaround_ticks} + {1'b0, timeout_ticks}
               : {1'b0, timeout_ticks};

  // Byte of the request frame at tx_idx
  always_comb begin
    unique case (tx_idx)
      3'd0: tx_b = req_slave;
      3'd1: tx_b = req_func;
      3'd2: tx_b = req_start[15:8];
      3'd3: tx_b = req_start[7:0];
      3'd4: tx_b = 8'(req_qty >> 8);
      3'd5: tx_b = 8'(req_qty);
      3'd6: tx_b = tx_crc[7:0];
      default: tx_b = tx_crc[15:8];
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= 4'd2;
      timeout_ticks <= 16'd200;
      turnaround_ticks <= 16'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgRetries: max_retries <= cfg_data[3:0];
        CfgTimeout: timeout_ticks <= cfg_data;
        CfgTurn: turnaround_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    crc_cmd <= '{load: 1'b0, seed: CrcInit, data: 8'h00};
    ram_we <= 1'b0;
    if (rst) begin
      seq <= S_IDLE;
      phase <= PH_IDLE;
      attempt_count <= '0;
      byte_position <= '0;
      segment_ticks <= '0;
      response_ticks <= '0;
      running_crc <= CrcInit;
      req_slave <= '0;
      req_func <= '0;
      req_start <= '0;
      req_qty <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 8; i++) counters[i] <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (seq)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            in_type <= s_axis_tuser;
            in_data <= s_axis_tdata;
            seq <= S_DISP;
          end
        end
        S_DISP: begin
          seq <= S_IDLE;
          priority if (in_type == ReqStart) begin
            if (phase == PH_IDLE) begin
              if (in_qty == 16'd0 || in_qty > 16'(MaxWords)) begin
                m_axis_tuser <= KindDone;
                m_axis_tdata <= {37'd0, StBadQty, 24'd0};
                m_axis_tlast <= 1'b1;
                m_axis_tvalid <= 1'b1;
              end else begin
                req_slave <= in_data[7:0];
                req_func <= in_data[15:8];
                req_start <= in_data[31:16];
                req_qty <= in_qty[QtyW-1:0];
                attempt_count <= '0;
                counters[CntTrans] <= counters[CntTrans] + 32'd1;
                tx_idx <= '0;
                tx_crc <= CrcInit;
                seq <= S_TXCRC;
                crc_cmd <= '{load: 1'b1, seed: CrcInit, data: in_data[7:0]};
              end
            end
          end else if (in_type == ReqByte) begin
            if (phase != PH_IDLE) begin
              seq <= S_RXEND;
              unique case (phase)
                PH_HEAD: begin
                  if (byte_position == 8'd0 && rx_b != req_slave) begin
                    counters[CntFrame] <= counters[CntFrame] + 32'd1;
                    in_data[58:56] <= StFrame;
                    seq <= S_OUT;
                  end else if (byte_position == 8'd1 && (rx_b & ExcMask) != 8'd0) begin
                    phase <= PH_EXHEAD;
                    seq <= S_IDLE;
                  end else if (byte_position == 8'd1 && rx_b != req_func) begin
                    counters[CntFrame] <= counters[CntFrame] + 32'd1;
                    in_data[58:56] <= StFrame;
                    seq <= S_OUT;
                  end else if (byte_position >= 8'd2 && {1'b0, rx_b} != expected) begin
                    counters[CntFrame] <= counters[CntFrame] + 32'd1;
                    in_data[58:56] <= StFrame;
                    seq <= S_OUT;
                  end else begin
                    crc_cmd <= '{load: 1'b1, seed: running_crc, data: rx_b};
                    seq <= S_RXCRC;
                  end
                end
                PH_EXHEAD: begin
                  phase <= PH_EXTAIL;
                  byte_position <= '0;
                  segment_ticks <= '0;
                  seq <= S_IDLE;
                end
                PH_EXTAIL: begin
                  byte_position <= byte_position + 8'd1;
                  seq <= S_IDLE;
                  if (byte_position >= 8'd1) begin
                    counters[CntExcept] <= counters[CntExcept] + 32'd1;
                    in_data[58:56] <= StExcept;
                    seq <= S_OUT;
                  end
                end
                default: begin
                  if ({1'b0, byte_position} < expected) begin
                    ram_we <= 1'b1;
                    ram_waddr <= byte_position[AddrW:1];
                    ram_wdata <= byte_position[0] ? {hold_word[15:8], rx_b}
                                                  : {rx_b, 8'h00};
                    if (!byte_position[0]) hold_word <= {rx_b, 8'h00};
                  end
                  crc_cmd <= '{load: 1'b1, seed: running_crc, data: rx_b};
                  seq <= S_RXCRC;
                end
              endcase
            end
          end else if (in_type == ReqTick) begin
            if (phase != PH_IDLE) begin
              response_ticks <= response_ticks + 32'd1;
              segment_ticks <= seg_inc;
              if (seg_inc >= limit) begin
                counters[CntTimeout] <= counters[CntTimeout] + 32'd1;
                in_data[58:56] <= StTimeout;
                seq <= S_OUT;
              end
            end
          end else if (in_type == ReqRead) begin
            m_axis_tuser <= KindCount;
            m_axis_tdata <= {5'd0, counters[in_data[58:56]], 27'd0};
            m_axis_tlast <= 1'b1;
            m_axis_tvalid <= 1'b1;
          end else if (in_type == ReqClear) begin
            for (int i = 0; i < 8; i++) counters[i] <= '0;
          end else begin
            // drop unknown kinds
          end
        end
        // Failure: retry or report (status parked in in_data[58:56])
        S_OUT: begin
          if (attempt_count < max_retries) begin
            attempt_count <= attempt_count + 4'd1;
            counters[CntRetry] <= counters[CntRetry] + 32'd1;
            counters[CntTrans] <= counters[CntTrans] + 32'd1;
            tx_idx <= '0;
            seq <= S_TXCRC;
            crc_cmd <= '{load: 1'b1, seed: CrcInit, data: req_slave};
          end else begin
            phase <= PH_IDLE;
            m_axis_tuser <= KindDone;
            m_axis_tdata <= {37'd0, in_data[58:56], 24'd0};
            m_axis_tlast <= 1'b1;
            m_axis_tvalid <= 1'b1;
            seq <= S_IDLE;
          end
        end
        // Run CRC over the six header bytes
        S_TXCRC: begin
          if (!crc_busy && !crc_cmd.load) begin
            if (tx_idx == 3'd5) begin
              tx_crc <= crc_val;
              tx_idx <= '0;
              seq <= S_TXSEND;
            end else begin
              tx_idx <= tx_idx + 3'd1;
              crc_cmd <= '{load: 1'b1, seed: crc_val, data: tx_b_next(tx_idx)};
            end
          end
        end
        S_TXSEND: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tuser <= KindTx;
            m_axis_tdata <= {56'd0, tx_b};
            m_axis_tlast <= (tx_idx == 3'd7);
            m_axis_tvalid <= 1'b1;
            tx_idx <= tx_idx + 3'd1;
            if (tx_idx == 3'd7) begin
              phase <= PH_HEAD;
              byte_position <= '0;
              segment_ticks <= '0;
              response_ticks <= '0;
              running_crc <= CrcInit;
              seq <= S_IDLE;
            end
          end
        end
        S_RXCRC: begin
          if (!crc_busy && !crc_cmd.load) begin
            running_crc <= crc_val;
            seq <= S_RXEND;
          end
        end
        // Advance position after a CRC-covered byte and check the CRC at frame end
        S_RXEND: begin
          seq <= S_IDLE;
          if (phase == PH_HEAD) begin
            if (byte_position >= 8'd2) begin
              phase <= PH_DATA;
              byte_position <= '0;
              segment_ticks <= '0;
            end else begin
              byte_position <= byte_position + 8'd1;
            end
          end else begin
            byte_position <= byte_position + 8'd1;
            if ({1'b0, byte_position} + 9'd1 >= expected + 9'd2) begin
              if (running_crc != 16'd0) begin
                counters[CntCrc] <= counters[CntCrc] + 32'd1;
                in_data[58:56] <= StCrc;
                seq <= S_OUT;
              end else begin
                counters[CntOk] <= counters[CntOk] + 32'd1;
                counters[CntTicks] <= response_ticks;
                phase <= PH_IDLE;
                word_idx <= '0;
                seq <= S_WREAD;
              end
            end
          end
        end
        S_WREAD: seq <= S_WSEND;
        S_WSEND: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tuser <= KindWord;
            m_axis_tdata <= {40'd0, ram_rdata, 8'd0};
            m_axis_tlast <= (word_idx + QtyW'(1) == req_qty);
            m_axis_tvalid <= 1'b1;
            word_idx <= word_idx + QtyW'(1);
            seq <= (word_idx + QtyW'(1) == req_qty) ? S_IDLE : S_WREAD;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No input is taken while a result still waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while result pending");
  // The last transmit transfer moves the phase to the header phase
  a_tx_then_head: assert property (@(posedge clk) disable iff (rst)
    (seq == S_TXSEND && tx_idx == 3'd7 && (!m_axis_tvalid || m_axis_tready))
    |=> phase == PH_HEAD)
    else $error("request sent without entering header phase");
  // Word emission only happens after the phase returned to idle
  a_words_idle: assert property (@(posedge clk) disable iff (rst)
    (seq == S_WSEND) |-> phase == PH_IDLE)
    else $error("words emitted while transaction active");
`endif

endmodule
